FILE: sv/zvd_pkg.sv
`timescale 1ns / 1ps

package zvd_pkg;

    localparam int COMP_W  = 24;
    localparam int LIMIT_W = 23;
    localparam int TIME_W  = 48;
    localparam int DUR_W   = 32;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int LSQ_W   = 2 * LIMIT_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int STEP_W  = 20;

    localparam logic [TIME_W-1:0] STEP_MIN_US = 48'd100;
    localparam logic [TIME_W-1:0] STEP_MAX_US = 48'd1000000;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic        [COMP_W-1:0] mag_t;
    typedef logic        [LIMIT_W-1:0] limit_t;

    typedef enum logic [2:0] {
        REG_HOR_LIMIT  = 3'd0,
        REG_VER_LIMIT  = 3'd1,
        REG_INS_LIMIT  = 3'd2,
        REG_RATE_LIMIT = 3'd3,
        REG_MIN_STATIC = 3'd4
    } reg_idx_t;

    function automatic mag_t mag(input comp_t c);
        comp_t neg;
        neg = -c;
        return c[COMP_W-1] ? mag_t'(neg) : mag_t'(c);
    endfunction

endpackage

FILE: sv/zvd_norm.sv
`timescale 1ns / 1ps

module zvd_norm (
    input  logic            aclk,
    input  logic            ld,
    input  zvd_pkg::comp_t  comp_x,
    input  zvd_pkg::comp_t  comp_y,
    input  zvd_pkg::comp_t  comp_z,
    input  zvd_pkg::limit_t limit,
    output logic            in_range
);
    import zvd_pkg::*;

    mag_t              mag_x, mag_y, mag_z;
    logic [SQ_W-1:0]   sq_x_next, sq_y_next, sq_z_next;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_z_reg;
    logic [LSQ_W-1:0]  limsq_next, limsq_reg;
    logic [SUM_W-1:0]  sum;

    assign mag_x      = mag(comp_x);
    assign mag_y      = mag(comp_y);
    assign mag_z      = mag(comp_z);
    assign sq_x_next  = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_y_next  = SQ_W'(mag_y) * SQ_W'(mag_y);
    assign sq_z_next  = SQ_W'(mag_z) * SQ_W'(mag_z);
    assign limsq_next = LSQ_W'(limit) * LSQ_W'(limit);

    always_ff @(posedge aclk) begin
        limsq_reg <= limsq_next;
        if (ld) begin
            sq_x_reg <= sq_x_next;
            sq_y_reg <= sq_y_next;
            sq_z_reg <= sq_z_next;
        end
    end

    assign sum      = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
    assign in_range = (sum <= SUM_W'(limsq_reg));

endmodule

FILE: sv/zero_velocity_detector.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// input     s_valid/s_ready    s_time_us, s_hor_speed, s_ver_speed, s_vel_*, s_rate_*
// result    m_valid/m_ready    m_zero_velocity, m_static_now, m_static_time_us
// config    APB psel/penable   paddr, pwdata, prdata (registers at 4*index)
//
// Three register stages: input, squares and time step, result. One request per cycle while the result is taken.
// An accepted request moves through the squares and time-step stage to the result stage.
// aresetn (synchronous) restores register defaults and clears the static duration.
// A stalled result holds its stage; earlier stages keep filling until they are full.

module zero_velocity_detector (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [47:0]         s_time_us,
    input  zvd_pkg::comp_t      s_hor_speed,
    input  zvd_pkg::comp_t      s_ver_speed,
    input  zvd_pkg::comp_t      s_vel_x,
    input  zvd_pkg::comp_t      s_vel_y,
    input  zvd_pkg::comp_t      s_vel_z,
    input  zvd_pkg::comp_t      s_rate_x,
    input  zvd_pkg::comp_t      s_rate_y,
    input  zvd_pkg::comp_t      s_rate_z,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_zero_velocity,
    output logic                m_static_now,
    output logic [31:0]         m_static_time_us,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import zvd_pkg::*;

    // configuration
    limit_t            hor_lim_reg, ver_lim_reg, ins_lim_reg, rate_lim_reg;
    logic [DUR_W-1:0]  min_static_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // stage 1
    logic              v1_reg;
    logic [TIME_W-1:0] t1_reg;
    comp_t             hs1_reg, vs1_reg;
    comp_t             vx1_reg, vy1_reg, vz1_reg;
    comp_t             rx1_reg, ry1_reg, rz1_reg;

    // stage 2
    logic              v2_reg;
    logic              hor_ok2_reg, ver_ok2_reg, step_ok2_reg;
    logic [STEP_W-1:0] step2_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic              have_prev_reg;
    logic [TIME_W:0]   diff;
    logic              step_ok_next;
    logic              hor_ok_next, ver_ok_next;
    mag_t              ver_mag;
    logic              vel_within, rate_within;

    // stage 3
    logic              v3_reg;
    logic              zero_vel_reg, static_now_reg;
    logic [DUR_W-1:0]  static_time_reg;
    logic              static_now_next;
    logic [DUR_W:0]    grown;
    logic [DUR_W-1:0]  static_time_next;

    logic              en1, en2, en3;

    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_HOR_LIMIT:  prdata = 32'(hor_lim_reg);
            REG_VER_LIMIT:  prdata = 32'(ver_lim_reg);
            REG_INS_LIMIT:  prdata = 32'(ins_lim_reg);
            REG_RATE_LIMIT: prdata = 32'(rate_lim_reg);
            REG_MIN_STATIC: prdata = min_static_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hor_lim_reg    <= 23'd205;
            ver_lim_reg    <= 23'd102;
            ins_lim_reg    <= 23'd307;
            rate_lim_reg   <= 23'd1144;
            min_static_reg <= 32'd500000;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_HOR_LIMIT:  hor_lim_reg    <= pwdata[LIMIT_W-1:0];
                REG_VER_LIMIT:  ver_lim_reg    <= pwdata[LIMIT_W-1:0];
                REG_INS_LIMIT:  ins_lim_reg    <= pwdata[LIMIT_W-1:0];
                REG_RATE_LIMIT: rate_lim_reg   <= pwdata[LIMIT_W-1:0];
                REG_MIN_STATIC: min_static_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // stage 1: capture request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
        if (en1 && s_valid) begin
            t1_reg  <= s_time_us;
            hs1_reg <= s_hor_speed;
            vs1_reg <= s_ver_speed;
            vx1_reg <= s_vel_x;
            vy1_reg <= s_vel_y;
            vz1_reg <= s_vel_z;
            rx1_reg <= s_rate_x;
            ry1_reg <= s_rate_y;
            rz1_reg <= s_rate_z;
        end
    end

    // stage 2: scalar limits, time step, squares
    assign ver_mag      = mag(vs1_reg);
    assign hor_ok_next  = (hs1_reg <= $signed({1'b0, hor_lim_reg}));
    assign ver_ok_next  = (ver_mag <= COMP_W'(ver_lim_reg));
    assign diff         = {1'b0, t1_reg} - {1'b0, prev_time_reg};
    assign step_ok_next = have_prev_reg && !diff[TIME_W]
                          && (diff[TIME_W-1:0] > STEP_MIN_US)
                          && (diff[TIME_W-1:0] < STEP_MAX_US);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg        <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_time_reg <= '0;
        end else if (en2) begin
            v2_reg <= v1_reg;
            if (v1_reg) begin
                have_prev_reg <= 1'b1;
                prev_time_reg <= t1_reg;
            end
        end
        if (en2 && v1_reg) begin
            hor_ok2_reg  <= hor_ok_next;
            ver_ok2_reg  <= ver_ok_next;
            step_ok2_reg <= step_ok_next;
            step2_reg    <= diff[STEP_W-1:0];
        end
    end

    zvd_norm u_vel_norm (
        .aclk     (aclk),
        .ld       (en2 && v1_reg),
        .comp_x   (vx1_reg),
        .comp_y   (vy1_reg),
        .comp_z   (vz1_reg),
        .limit    (ins_lim_reg),
        .in_range (vel_within)
    );

    zvd_norm u_rate_norm (
        .aclk     (aclk),
        .ld       (en2 && v1_reg),
        .comp_x   (rx1_reg),
        .comp_y   (ry1_reg),
        .comp_z   (rz1_reg),
        .limit    (rate_lim_reg),
        .in_range (rate_within)
    );

    // stage 3: static decision and duration
    assign static_now_next = hor_ok2_reg && ver_ok2_reg && vel_within && rate_within;
    assign grown           = {1'b0, static_time_reg} + (DUR_W + 1)'(step2_reg);

    always_comb begin
        if (!static_now_next) begin
            static_time_next = '0;
        end else if (step_ok2_reg) begin
            static_time_next = grown[DUR_W] ? '1 : grown[DUR_W-1:0];
        end else begin
            static_time_next = static_time_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg          <= 1'b0;
            static_time_reg <= '0;
        end else if (en3) begin
            v3_reg <= v2_reg;
            if (v2_reg) begin
                static_time_reg <= static_time_next;
            end
        end
        if (en3 && v2_reg) begin
            static_now_reg <= static_now_next;
            zero_vel_reg   <= static_now_next && (static_time_next >= min_static_reg);
        end
    end

    assign m_valid          = v3_reg;
    assign m_zero_velocity  = zero_vel_reg;
    assign m_static_now     = static_now_reg;
    assign m_static_time_us = static_time_reg;

endmodule

FILE: dv/zero_velocity_detector_test.sv
`timescale 1ns / 1ps

module zero_velocity_detector_test;
    import zvd_pkg::*;

    localparam int      SPARE_REG_LO = 5;
    localparam int      SPARE_REG_HI = 7;
    localparam int      SETTLE_CYCLES = 8;
    localparam longint  COMP_MAX = 8388607;
    localparam realtime RUN_LIMIT = 2_000_000ns;

    typedef struct {
        logic [TIME_W-1:0] time_us;
        comp_t             horiz_spd;
        comp_t             vert_spd;
        comp_t             vel [3];
        comp_t             rate [3];
    } sample_t;

    typedef struct {
        logic              zero_velocity;
        logic              static_now;
        logic [DUR_W-1:0]  static_time_us;
    } verdict_t;

    class zupt_scoreboard;
        limit_t            hor_limit;
        limit_t            ver_limit;
        limit_t            ins_limit;
        limit_t            rate_limit;
        logic [DUR_W-1:0]  min_static;
        logic [TIME_W-1:0] last_time;
        bit                seen_sample;
        logic [DUR_W-1:0]  still_time;
        verdict_t          verdicts [$];
        int                errors;
        int                n_samples;
        int                n_results;
        int                n_static;
        int                n_zero;

        function new();
            hor_limit   = 205;
            ver_limit   = 102;
            ins_limit   = 307;
            rate_limit  = 1144;
            min_static  = 500000;
            last_time   = '0;
            seen_sample = 0;
            still_time  = '0;
        endfunction

        function void report(input string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void set_reg(input int idx, input logic [31:0] value);
            case (idx)
                REG_HOR_LIMIT:  hor_limit  = value[LIMIT_W-1:0];
                REG_VER_LIMIT:  ver_limit  = value[LIMIT_W-1:0];
                REG_INS_LIMIT:  ins_limit  = value[LIMIT_W-1:0];
                REG_RATE_LIMIT: rate_limit = value[LIMIT_W-1:0];
                REG_MIN_STATIC: min_static = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input int idx);
            case (idx)
                REG_HOR_LIMIT:  return 32'(hor_limit);
                REG_VER_LIMIT:  return 32'(ver_limit);
                REG_INS_LIMIT:  return 32'(ins_limit);
                REG_RATE_LIMIT: return 32'(rate_limit);
                REG_MIN_STATIC: return min_static;
                default:        return '0;
            endcase
        endfunction

        function bit norm_within(input comp_t c [3], input limit_t lim);
            longint sum;
            sum = 0;
            foreach (c[k])
                sum += longint'(c[k]) * longint'(c[k]);
            return sum <= longint'(lim) * longint'(lim);
        endfunction

        function void note_sample(input sample_t s);
            longint           step;
            longint           vabs;
            bit               still;
            logic [DUR_W:0]   grown;
            verdict_t         v;
            vabs = longint'(s.vert_spd);
            if (vabs < 0)
                vabs = -vabs;
            still = longint'(s.horiz_spd) <= longint'(hor_limit) &&
                    vabs <= longint'(ver_limit) &&
                    norm_within(s.vel, ins_limit) &&
                    norm_within(s.rate, rate_limit);
            step = seen_sample ? longint'(s.time_us) - longint'(last_time) : 0;
            last_time   = s.time_us;
            seen_sample = 1;
            if (!still) begin
                still_time = '0;
            end else if (step > longint'(STEP_MIN_US) && step < longint'(STEP_MAX_US)) begin
                grown      = {1'b0, still_time} + (DUR_W+1)'(step);
                still_time = grown[DUR_W] ? '1 : grown[DUR_W-1:0];
            end
            v.zero_velocity  = still && (still_time >= min_static);
            v.static_now     = still;
            v.static_time_us = still_time;
            verdicts.push_back(v);
            n_samples++;
            if (still)
                n_static++;
            if (v.zero_velocity)
                n_zero++;
        endfunction

        function void check_result(input logic z, input logic s, input logic [DUR_W-1:0] t);
            verdict_t v;
            n_results++;
            if (verdicts.size() == 0) begin
                report($sformatf("result %0d arrived with no sample pending", n_results));
                return;
            end
            v = verdicts.pop_front();
            if (z !== v.zero_velocity)
                report($sformatf("result %0d zero_velocity %b, want %b",
                                 n_results, z, v.zero_velocity));
            if (s !== v.static_now)
                report($sformatf("result %0d static_now %b, want %b",
                                 n_results, s, v.static_now));
            if (t !== v.static_time_us)
                report($sformatf("result %0d static_time_us %0d, want %0d",
                                 n_results, t, v.static_time_us));
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [47:0]       s_time_us = '0;
    comp_t             s_hor_speed = '0;
    comp_t             s_ver_speed = '0;
    comp_t             s_vel_x = '0;
    comp_t             s_vel_y = '0;
    comp_t             s_vel_z = '0;
    comp_t             s_rate_x = '0;
    comp_t             s_rate_y = '0;
    comp_t             s_rate_z = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_zero_velocity;
    logic              m_static_now;
    logic [31:0]       m_static_time_us;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic [TIME_W-1:0] cur_time = '0;
    zupt_scoreboard    sb = new();

    zero_velocity_detector DUT (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_zero_velocity, m_static_now, m_static_time_us);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(input sample_t smp);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_time_us   <= smp.time_us;
        s_hor_speed <= smp.horiz_spd;
        s_ver_speed <= smp.vert_spd;
        s_vel_x     <= smp.vel[0];
        s_vel_y     <= smp.vel[1];
        s_vel_z     <= smp.vel[2];
        s_rate_x    <= smp.rate[0];
        s_rate_y    <= smp.rate[1];
        s_rate_z    <= smp.rate[2];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_sample(smp);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 5'(idx * 4);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== sb.reg_value(idx))
            sb.report($sformatf("register %0d reads %0h, want %0h",
                                idx, prdata, sb.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_limits(input logic [31:0] hor, input logic [31:0] ver,
                                  input logic [31:0] ins, input logic [31:0] rate,
                                  input logic [31:0] min_us);
        write_reg(REG_HOR_LIMIT, hor);
        write_reg(REG_VER_LIMIT, ver);
        write_reg(REG_INS_LIMIT, ins);
        write_reg(REG_RATE_LIMIT, rate);
        write_reg(REG_MIN_STATIC, min_us);
        write_reg(int'($urandom_range(SPARE_REG_HI, SPARE_REG_LO)), $urandom);
        for (int k = REG_HOR_LIMIT; k <= REG_MIN_STATIC; k++)
            check_reg(k);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic sample_t make_sample(input longint t, input int hs, input int vs,
                                            input int vx, input int vy, input int vz,
                                            input int rx, input int ry, input int rz);
        sample_t s;
        s.time_us   = TIME_W'(t);
        s.horiz_spd = comp_t'(hs);
        s.vert_spd  = comp_t'(vs);
        s.vel[0]    = comp_t'(vx);
        s.vel[1]    = comp_t'(vy);
        s.vel[2]    = comp_t'(vz);
        s.rate[0]   = comp_t'(rx);
        s.rate[1]   = comp_t'(ry);
        s.rate[2]   = comp_t'(rz);
        cur_time    = s.time_us;
        return s;
    endfunction

    function automatic longint span_for(input limit_t lim, input int scale);
        if (scale < 6)
            return longint'(lim) / 2;
        if (scale < 9)
            return longint'(lim);
        return longint'(lim) + longint'(lim) / 4 + 2;
    endfunction

    function automatic comp_t rand_comp(input longint span);
        longint s;
        s = (span > COMP_MAX) ? COMP_MAX : span;
        return comp_t'(longint'($urandom_range(32'(2 * s))) - s);
    endfunction

    function automatic sample_t rand_sample(input bit steady);
        sample_t s;
        longint  step;
        int      pick;
        int      scale;
        if (!steady && $urandom_range(99) < 25) begin
            s.time_us   = TIME_W'({$urandom, $urandom});
            s.horiz_spd = comp_t'($urandom);
            s.vert_spd  = comp_t'($urandom);
            foreach (s.vel[k])
                s.vel[k] = comp_t'($urandom);
            foreach (s.rate[k])
                s.rate[k] = comp_t'($urandom);
            cur_time = s.time_us;
            return s;
        end
        pick = int'($urandom_range(99));
        if (steady)
            step = longint'($urandom_range(999999, 990000));
        else if (pick < 60)
            step = longint'($urandom_range(20000, 101));
        else if (pick < 70)
            step = longint'($urandom_range(999999, 20001));
        else if (pick < 78) begin
            case ($urandom_range(3))
                0:       step = 100;
                1:       step = 101;
                2:       step = 999999;
                default: step = 1000000;
            endcase
        end else if (pick < 86)
            step = longint'($urandom_range(100));
        else if (pick < 93)
            step = longint'($urandom_range(3000000, 1000001));
        else
            step = -longint'($urandom_range(5000));
        cur_time  = cur_time + TIME_W'(step);
        s.time_us = cur_time;
        scale = steady ? 0 : int'($urandom_range(9));
        s.horiz_spd = rand_comp(span_for(sb.hor_limit, scale));
        s.vert_spd  = rand_comp(span_for(sb.ver_limit, scale));
        foreach (s.vel[k])
            s.vel[k] = rand_comp(span_for(sb.ins_limit, scale));
        foreach (s.rate[k])
            s.rate[k] = rand_comp(span_for(sb.rate_limit, scale));
        return s;
    endfunction

    task automatic send_random(input int count, input bit steady);
        repeat (count) send_sample(rand_sample(steady));
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = REG_HOR_LIMIT; k <= REG_MIN_STATIC; k++)
            check_reg(k);

        // first sample, then the time-step window edges
        send_sample(make_sample(1000, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1100, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1201, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1001200, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(2001200, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(2001200, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1500000, 0, 0, 0, 0, 0, 0, 0, 0));
        // speed limits
        send_sample(make_sample(1505000, -8388608, 102, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1510000, 205, -102, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1515000, 206, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1520000, 0, 103, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1525000, 0, -103, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1530000, 0, -8388608, 0, 0, 0, 0, 0, 0));
        // norm limits
        send_sample(make_sample(1535000, 0, 0, 307, 0, 0, 0, 0, 0));
        send_sample(make_sample(1540000, 0, 0, 308, 0, 0, 0, 0, 0));
        send_sample(make_sample(1545000, 0, 0, 177, -177, 177, 0, 0, 0));
        send_sample(make_sample(1550000, 0, 0, 0, 0, 0, 0, 1144, 0));
        send_sample(make_sample(1555000, 0, 0, 0, 0, 0, 0, 0, -1145));
        send_sample(make_sample(1560000, 8388607, 8388607, 8388607, 8388607, 8388607,
                                8388607, 8388607, 8388607));
        send_sample(make_sample(1565000, -8388608, -8388608, -8388608, -8388608, -8388608,
                                -8388608, -8388608, -8388608));
        // timestamp extremes and wrap back to zero
        send_sample(make_sample(longint'(48'hFFFF_FFFF_FFFF), 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(150, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_results();

        // free flow, then a long still run
        program_limits(2000, 1000, 3000, 20000, 32'd100_000_000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(300, 0);
        send_random(300, 1);
        drain_results();

        program_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_idle_pct  = 79;
        recv_stall_pct = 0;
        send_random(450, 0);
        drain_results();

        program_limits(32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000, 0);
        send_idle_pct  = 0;
        recv_stall_pct = 79;
        send_random(450, 0);
        drain_results();

        program_limits($urandom_range(4000) | ($urandom & 32'hFF80_0000),
                       $urandom_range(4000) | ($urandom & 32'hFF80_0000),
                       $urandom_range(4000) | ($urandom & 32'hFF80_0000),
                       $urandom_range(40000) | ($urandom & 32'hFF80_0000),
                       $urandom_range(3000000));
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_random(250, 0);
        // hold off until the pipeline has emptied
        drain_results();
        send_random(250, 0);

        recv_stall_pct = 0;
        drain_results();

        $display("Ran %0d samples (%0d static, %0d at zero velocity), %0d results checked,",
                 sb.n_samples, sb.n_static, sb.n_zero, sb.n_results);
        $display("across five limit settings with free flow, gaps, stalls and a long still run.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
